// File: hdl/opf_pkg.sv
// Package for the oil paint pixel filter.
// Holds controller states, command/status bundles and fixed constants.
// No dependencies.
`timescale 1ns / 1ps

package opf_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_RADIUS = 2'd2;
	localparam logic [1:0] REG_LEVELS = 2'd3;

	localparam int CFG_DATA_W = 13;
	localparam int MAX_HEIGHT = 4096;

	// reset values of the configuration registers
	localparam logic [10:0] RST_WIDTH  = 11'd1024;
	localparam logic [12:0] RST_HEIGHT = 13'd768;
	localparam logic [3:0]  RST_RADIUS = 4'd3;
	localparam logic [5:0]  RST_LEVELS = 6'd20;

	// bin = (2*s*lev + 765) / 1530, done as a multiply by 2^28/1530 rounded up
	localparam logic [16:0] BIN_BIAS  = 17'd765;
	localparam logic [17:0] BIN_RECIP = 18'd175449;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_WIN   = 9'b000000010,
		S_DRAIN = 9'b000000100,
		S_SEL   = 9'b000001000,
		S_SELW  = 9'b000010000,
		S_RD    = 9'b000100000,
		S_DLD   = 9'b001000000,
		S_DIV   = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	typedef struct packed {
		logic load;
		logic win_step;
		logic sel_step;
		logic rd_best;
		logic div_load;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic interior;
		logic win_last;
		logic acc_idle;
		logic sel_last;
		logic div_last;
	} sts_t;

endpackage

// File: hdl/oil_paint_pixel_filter.sv
// Channel  | Signals                                   | Moves
// cfg      | cfg_valid cfg_ready cfg_index cfg_data    | one register write per transfer
// in       | in_valid in_ready red/green/blue_in frame_start | one pixel per transfer
// out      | out_valid out_ready red/green/blue_out frame_end | one pixel per transfer
//
// Border pixel: the result is loaded without a window scan. Interior pixel: the
// result is set by one row store read per window pixel, a 4 stage accumulate
// drain, one bin memory read per bin in the scan and an 8 step divider.
// Reset clears position and control; the row store is not cleared.
// A held result stalls the final load; no next pixel is accepted meanwhile.
// Top level of the oil paint pixel filter. Depends on opf_pkg, opf_ctrl, opf_dp.
`timescale 1ns / 1ps

module oil_paint_pixel_filter #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 8,
	parameter int MAX_LEVELS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [1:0]                     cfg_index,
	input  logic [opf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     red_in,
	input  logic [7:0]                     green_in,
	input  logic [7:0]                     blue_in,
	input  logic                           frame_start,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [7:0]                     red_out,
	output logic [7:0]                     green_out,
	output logic [7:0]                     blue_out,
	output logic                           frame_end
);
	import opf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// registers take a write at any time
	assign cfg_ready = 1'b1;

	opf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	opf_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_RADIUS (MAX_RADIUS),
		.MAX_LEVELS (MAX_LEVELS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.red_in      (red_in),
		.green_in    (green_in),
		.blue_in     (blue_in),
		.frame_start (frame_start),
		.cmd         (cmd),
		.sts         (sts),
		.red_out     (red_out),
		.green_out   (green_out),
		.blue_out    (blue_out),
		.frame_end   (frame_end)
	);

endmodule

// File: hdl/opf_ctrl.sv
// Controller of the oil paint pixel filter: sequences one pixel at a time.
// Depends on opf_pkg.
`timescale 1ns / 1ps

module opf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  opf_pkg::sts_t sts,
	output opf_pkg::cmd_t cmd
);
	import opf_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.interior ? S_WIN : S_OUT;
				end
			end
			S_WIN: begin
				cmd.win_step = 1'b1;
				if (sts.win_last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (sts.acc_idle) state_d = S_SEL;
			end
			S_SEL: begin
				cmd.sel_step = 1'b1;
				if (sts.sel_last) state_d = S_SELW;
			end
			S_SELW: state_d = S_RD;
			S_RD: begin
				cmd.rd_best = 1'b1;
				state_d     = S_DLD;
			end
			S_DLD: begin
				cmd.div_load = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// hold state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: hdl/opf_dp.sv
// Datapath of the oil paint pixel filter: config, position, row store,
// bin accumulation, bin selection and the per-channel dividers.
// Depends on opf_pkg.
`timescale 1ns / 1ps

module opf_dp #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 8,
	parameter int MAX_LEVELS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [1:0]                       cfg_index,
	input  logic [opf_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [7:0]                       red_in,
	input  logic [7:0]                       green_in,
	input  logic [7:0]                       blue_in,
	input  logic                             frame_start,
	input  opf_pkg::cmd_t                    cmd,
	output opf_pkg::sts_t                    sts,
	output logic [7:0]                       red_out,
	output logic [7:0]                       green_out,
	output logic [7:0]                       blue_out,
	output logic                             frame_end
);
	import opf_pkg::*;

	localparam int SLOTS = MAX_RADIUS + 1;
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int CW    = $clog2(MAX_WIDTH + 1);
	localparam int SLW   = $clog2(SLOTS);
	localparam int RW    = $clog2(MAX_RADIUS + 1);
	localparam int BNW   = $clog2(MAX_LEVELS + 1);
	localparam int CNW   = $clog2(MAX_RADIUS * MAX_RADIUS + 1);
	localparam int SMW   = CNW + 8;
	localparam int BEW   = CNW + 3 * SMW;
	localparam int NMW   = SMW + 1;
	localparam int HW    = 13;

	// configuration registers
	logic [10:0] width_q;
	logic [12:0] height_q;
	logic [3:0]  radius_q;
	logic [5:0]  levels_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			radius_q <= RST_RADIUS;
			levels_q <= RST_LEVELS;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[10:0];
				REG_HEIGHT: height_q <= cfg_data[12:0];
				REG_RADIUS: radius_q <= cfg_data[3:0];
				REG_LEVELS: levels_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// clamp registers to their working ranges
	logic [CW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic [RW-1:0] rad;
	logic [5:0]    lev;

	always_comb begin
		if (width_q == '0) w_eff = CW'(1);
		else if (32'(width_q) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
		else w_eff = CW'(width_q);
		if (height_q == '0) h_eff = HW'(1);
		else if (32'(height_q) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
		else h_eff = height_q;
		if (radius_q == '0) rad = RW'(1);
		else if (32'(radius_q) > MAX_RADIUS) rad = RW'(MAX_RADIUS);
		else rad = RW'(radius_q);
		if (levels_q == '0) lev = 6'd1;
		else if (32'(levels_q) > MAX_LEVELS) lev = 6'(MAX_LEVELS);
		else lev = levels_q;
	end

	// position of the incoming pixel
	logic [CW-1:0]  col_q, col0, colp;
	logic [HW-1:0]  row_q, row0, rowp;
	logic [SLW-1:0] slot_q, slotp;
	logic           col_end, row_end, row_wrap;

	always_comb begin
		col0     = frame_start ? '0 : col_q;
		colp     = (col0 >= w_eff) ? '0 : col0;
		row0     = frame_start ? '0 : row_q;
		row_wrap = frame_start || (row0 >= h_eff);
		rowp     = row_wrap ? '0 : row0;
		slotp    = row_wrap ? '0 : slot_q;
		col_end  = (colp == w_eff - CW'(1));
		row_end  = (rowp == h_eff - HW'(1));
	end

	assign sts.interior = ((CW+1)'(colp) >= (CW+1)'(rad))
		&& ((CW+1)'(colp) + (CW+1)'(rad) < (CW+1)'(w_eff))
		&& ((HW+1)'(rowp) >= (HW+1)'(rad))
		&& ((HW+1)'(rowp) + (HW+1)'(rad) < (HW+1)'(h_eff));

	// window scan counters
	logic [SLW-1:0] wslot_q;
	logic [XW-1:0]  wx0_q, wx_q;
	logic [RW-1:0]  dx_q, dy_q;
	logic           dx_end;
	logic [SLW:0]   slot_diff;

	assign dx_end       = (dx_q == rad - RW'(1));
	assign sts.win_last = dx_end && (dy_q == rad - RW'(1));
	assign slot_diff    = (SLW+1)'(slotp) - (SLW+1)'(rad);

	// selection and divider control
	logic [BNW-1:0] sel_idx_q, sel_idx_s1, best_idx_q;
	logic [CNW-1:0] best_cnt_q;
	logic           sel_v_s1;
	logic [2:0]     step_q;

	assign sts.sel_last = (sel_idx_q == BNW'(lev));
	assign sts.div_last = (step_q == 3'd0);

	// accumulation pipeline control
	logic             v_s1, v_s2, v_s3, v_s4, fw_v_q;
	logic [MAX_LEVELS:0] bvalid_q;
	logic [BNW-1:0]   bin_s3, bin_s4, fw_bin_q, bin_ra;
	logic [34:0]      prod_s3;

	assign sts.acc_idle = !(v_s1 || v_s2 || v_s3 || v_s4);
	assign bin_s3 = BNW'(prod_s3[33:28]);

	always_comb begin
		if (cmd.sel_step) bin_ra = sel_idx_q;
		else if (cmd.rd_best) bin_ra = best_idx_q;
		else bin_ra = bin_s3;
	end

	// bin entry merge at the write stage
	logic [BEW-1:0] bin_rd_q, fw_data_q, acc_old, acc_new;
	logic           bin_rv_q;
	logic [23:0]    pix_s4;
	logic [CNW-1:0] rd_cnt;

	always_comb begin
		if (fw_v_q && (fw_bin_q == bin_s4)) acc_old = fw_data_q;
		else if (bin_rv_q) acc_old = bin_rd_q;
		else acc_old = '0;
		acc_new = acc_old + {CNW'(1), SMW'(pix_s4[23:16]), SMW'(pix_s4[15:8]),
			SMW'(pix_s4[7:0])};
		rd_cnt = bin_rv_q ? bin_rd_q[BEW-1 -: CNW] : '0;
	end

	// control registers of the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			slot_q     <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			fw_v_q     <= 1'b0;
			bvalid_q   <= '0;
			sel_v_s1   <= 1'b0;
			sel_idx_q  <= '0;
			best_idx_q <= '0;
			best_cnt_q <= '0;
			dx_q       <= '0;
			dy_q       <= '0;
			step_q     <= '0;
		end else begin
			v_s1     <= cmd.win_step;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4     <= v_s3;
			fw_v_q   <= v_s4;
			sel_v_s1 <= cmd.sel_step;
			// advance position on each accepted pixel
			if (cmd.load) begin
				if (col_end) begin
					col_q <= '0;
					if (row_end) begin
						row_q  <= '0;
						slot_q <= '0;
					end else begin
						row_q  <= rowp + HW'(1);
						slot_q <= (slotp == SLW'(SLOTS - 1)) ? '0 : slotp + SLW'(1);
					end
				end else begin
					col_q  <= colp + CW'(1);
					row_q  <= rowp;
					slot_q <= slotp;
				end
				bvalid_q   <= '0;
				sel_idx_q  <= '0;
				best_idx_q <= '0;
				best_cnt_q <= '0;
				dx_q       <= '0;
				dy_q       <= '0;
			end
			// step through the window
			if (cmd.win_step) begin
				if (dx_end) begin
					dx_q <= '0;
					dy_q <= dy_q + RW'(1);
				end else begin
					dx_q <= dx_q + RW'(1);
				end
			end
			// mark bins that hold data
			if (v_s4) bvalid_q[bin_s4] <= 1'b1;
			// scan bins for the most frequent one
			if (cmd.sel_step) sel_idx_q <= sel_idx_q + BNW'(1);
			if (sel_v_s1 && (rd_cnt > best_cnt_q)) begin
				best_cnt_q <= rd_cnt;
				best_idx_q <= sel_idx_s1;
			end
			if (cmd.div_load) step_q <= 3'd7;
			else if (cmd.div_step) step_q <= step_q - 3'd1;
		end
	end

	// row store: one write at accept, one registered read in the window scan
	logic [23:0] row_mem [0:SLOTS*(2**XW)-1];
	logic [23:0] p_s1;

	always_ff @(posedge clk) begin
		if (cmd.load) row_mem[{slotp, colp[XW-1:0]}] <= {red_in, green_in, blue_in};
		if (cmd.win_step) p_s1 <= row_mem[{wslot_q, wx_q}];
	end

	// window base and address walk
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			wslot_q <= slot_diff[SLW] ? SLW'(slot_diff + (SLW+1)'(SLOTS)) : slot_diff[SLW-1:0];
			wx0_q   <= XW'(colp - CW'(rad));
			wx_q    <= XW'(colp - CW'(rad));
		end else if (cmd.win_step) begin
			if (dx_end) begin
				wx_q    <= wx0_q;
				wslot_q <= (wslot_q == SLW'(SLOTS - 1)) ? '0 : wslot_q + SLW'(1);
			end else begin
				wx_q <= wx_q + XW'(1);
			end
		end
	end

	// bin index: scale intensity by levels, then multiply by the reciprocal
	logic [9:0]  sum3;
	logic [15:0] sl;
	logic [16:0] n_s2;
	logic [23:0] pix_s2, pix_s3;

	assign sum3 = 10'(p_s1[23:16]) + 10'(p_s1[15:8]) + 10'(p_s1[7:0]);
	assign sl   = 16'(sum3) * 16'(lev);

	always_ff @(posedge clk) begin
		n_s2    <= {sl, 1'b0} + BIN_BIAS;
		pix_s2  <= p_s1;
		prod_s3 <= 35'(n_s2) * 35'(BIN_RECIP);
		pix_s3  <= pix_s2;
		bin_s4  <= bin_s3;
		pix_s4  <= pix_s3;
	end

	// bin memory: one registered read, one write per cycle
	logic [BEW-1:0] bin_mem [0:MAX_LEVELS];

	always_ff @(posedge clk) begin
		bin_rd_q <= bin_mem[bin_ra];
		bin_rv_q <= bvalid_q[bin_ra];
		if (v_s4) bin_mem[bin_s4] <= acc_new;
		fw_bin_q   <= bin_s4;
		fw_data_q  <= acc_new;
		sel_idx_s1 <= sel_idx_q;
	end

	// dividers: round(sum / count) as (2*sum + count) / (2*count), one bit a step
	logic [NMW-1:0] num_r_q, num_g_q, num_b_q, dsh_q;
	logic [7:0]     res_r_q, res_g_q, res_b_q;
	logic           end_q;
	logic [CNW-1:0] div_cnt;

	assign div_cnt = bin_rd_q[BEW-1 -: CNW];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_r_q <= red_in;
			res_g_q <= green_in;
			res_b_q <= blue_in;
			end_q   <= col_end && row_end;
		end
		if (cmd.div_load) begin
			num_r_q <= {bin_rd_q[3*SMW-1 -: SMW], 1'b0} + NMW'(div_cnt);
			num_g_q <= {bin_rd_q[2*SMW-1 -: SMW], 1'b0} + NMW'(div_cnt);
			num_b_q <= {bin_rd_q[SMW-1:0], 1'b0} + NMW'(div_cnt);
			dsh_q   <= NMW'({div_cnt, 8'b0});
			res_r_q <= '0;
			res_g_q <= '0;
			res_b_q <= '0;
		end else if (cmd.div_step) begin
			if (num_r_q >= dsh_q) begin
				num_r_q         <= num_r_q - dsh_q;
				res_r_q[step_q] <= 1'b1;
			end
			if (num_g_q >= dsh_q) begin
				num_g_q         <= num_g_q - dsh_q;
				res_g_q[step_q] <= 1'b1;
			end
			if (num_b_q >= dsh_q) begin
				num_b_q         <= num_b_q - dsh_q;
				res_b_q[step_q] <= 1'b1;
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			red_out   <= res_r_q;
			green_out <= res_g_q;
			blue_out  <= res_b_q;
			frame_end <= end_q;
		end
	end

endmodule

// File: hdl/opf_checker.sv
// Port-level checks for the oil paint pixel filter, bound to the top level.
// Depends on oil_paint_pixel_filter.
`timescale 1ns / 1ps

module opf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_valid,
	input logic       cfg_ready,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] red_out,
	input logic [7:0] green_out,
	input logic [7:0] blue_out,
	input logic       frame_end
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red_out) && $stable(green_out)
			&& $stable(blue_out) && $stable(frame_end))
		else $error("stalled result changed");

	// one pixel in flight: busy right after an input transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// a new result comes with the input side free again
	a_ready_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result appeared while still busy");

	// configuration writes never stall
	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

endmodule

bind oil_paint_pixel_filter opf_checker u_opf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.red_out   (red_out),
	.green_out (green_out),
	.blue_out  (blue_out),
	.frame_end (frame_end)
);

// File: tb/oil_paint_pixel_filter_test.sv
// Self-checking testbench for the oil paint pixel filter.
// Predicts every filtered pixel in the testbench and compares results in order.
// Depends on opf_pkg and oil_paint_pixel_filter.
`timescale 1ns / 1ps

module oil_paint_pixel_filter_test;
	import opf_pkg::*;

	localparam int WIDTH_MAX  = 1024;
	localparam int RADIUS_MAX = 8;
	localparam int LEVELS_MAX = 32;
	localparam int HEIGHT_MAX = 4096;
	localparam int ROW_SLOTS  = RADIUS_MAX + 1;
	localparam int SETTLE     = 160;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int CALM_START = 30000;
	localparam int CALM_END   = 70000;
	localparam int PIX_TOTAL  = 1650;

	typedef enum logic [1:0] {K_PIX, K_CFG, K_DRAIN} item_kind_t;

	typedef struct {
		item_kind_t  kind;
		logic [1:0]  index;
		logic [12:0] data;
		logic [7:0]  r, g, b;
		logic        fs;
	} stim_t;

	typedef struct {
		logic [7:0] r, g, b;
		logic       fe;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0, cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0, in_ready;
	logic [7:0] red_in = '0, green_in = '0, blue_in = '0;
	logic frame_start = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] red_out, green_out, blue_out;
	logic frame_end;

	stim_t  pending[$];
	pixel_t filtered_q[$];
	int     errors = 0;
	int     cyc = 0;
	int     quiet = 0;
	int     total_pix = 0;

	// predictor state
	logic [23:0] line_mem [ROW_SLOTS*WIDTH_MAX];
	int col_pos = 0, row_pos = 0;
	int cfg_w = RST_WIDTH, cfg_h = RST_HEIGHT, cfg_rad = RST_RADIUS, cfg_lev = RST_LEVELS;

	oil_paint_pixel_filter u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.frame_start(frame_start),
		.out_valid(out_valid), .out_ready(out_ready),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out),
		.frame_end(frame_end)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int clampi(int v, int lo, int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic bit idle_now();
		if (cyc >= CALM_START && cyc < CALM_END)
			return 1'b0;
		return $urandom_range(99) < 29;
	endfunction

	// apply a register write to the predictor's copy
	task automatic apply_cfg(stim_t s);
		case (s.index)
			REG_WIDTH:  cfg_w = s.data[10:0];
			REG_HEIGHT: cfg_h = s.data[12:0];
			REG_RADIUS: cfg_rad = s.data[3:0];
			REG_LEVELS: cfg_lev = s.data[5:0];
			default: ;
		endcase
	endtask

	// compute the filtered pixel for one accepted input
	task automatic paint_pixel(stim_t s);
		int w, h, rad, lev, col, row, best, best_cnt, bin, pr, pg, pb;
		int cnt [LEVELS_MAX+1];
		int sr [LEVELS_MAX+1];
		int sg [LEVELS_MAX+1];
		int sb [LEVELS_MAX+1];
		logic [23:0] p;
		pixel_t res;
		w = clampi(cfg_w, 1, WIDTH_MAX);
		h = clampi(cfg_h, 1, HEIGHT_MAX);
		rad = clampi(cfg_rad, 1, RADIUS_MAX);
		lev = clampi(cfg_lev, 1, LEVELS_MAX);
		if (s.fs) begin
			col_pos = 0;
			row_pos = 0;
		end
		if (col_pos >= w) col_pos = 0;
		if (row_pos >= h) row_pos = 0;
		col = col_pos;
		row = row_pos;
		res.r = s.r; res.g = s.g; res.b = s.b;
		if (col >= rad && col + rad < w && row >= rad && row + rad < h) begin
			for (int n = 0; n <= LEVELS_MAX; n++) begin
				cnt[n] = 0; sr[n] = 0; sg[n] = 0; sb[n] = 0;
			end
			for (int y = row - rad; y < row; y++)
				for (int x = col - rad; x < col; x++) begin
					p = line_mem[(y % ROW_SLOTS) * WIDTH_MAX + x];
					pr = p[23:16]; pg = p[15:8]; pb = p[7:0];
					bin = (2 * (pr + pg + pb) * lev + 765) / 1530;
					if (bin > LEVELS_MAX) bin = LEVELS_MAX;
					cnt[bin]++;
					sr[bin] += pr; sg[bin] += pg; sb[bin] += pb;
				end
			best = 0;
			best_cnt = 0;
			for (int n = 0; n <= lev; n++)
				if (cnt[n] > best_cnt) begin
					best_cnt = cnt[n];
					best = n;
				end
			if (best_cnt != 0) begin
				res.r = 8'(clampi((2 * sr[best] + best_cnt) / (2 * best_cnt), 0, 255));
				res.g = 8'(clampi((2 * sg[best] + best_cnt) / (2 * best_cnt), 0, 255));
				res.b = 8'(clampi((2 * sb[best] + best_cnt) / (2 * best_cnt), 0, 255));
			end
		end
		line_mem[(row % ROW_SLOTS) * WIDTH_MAX + col] = {s.r, s.g, s.b};
		res.fe = (col + 1 >= w) && (row + 1 >= h);
		if (col + 1 >= w) begin
			col_pos = 0;
			row_pos = (row + 1 >= h) ? 0 : row + 1;
		end else begin
			col_pos = col + 1;
		end
		filtered_q.push_back(res);
	endtask

	task automatic push_pix(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
		stim_t s;
		s.kind = K_PIX; s.index = REG_WIDTH; s.data = '0;
		s.r = r; s.g = g; s.b = b; s.fs = fs;
		pending.push_back(s);
		total_pix++;
	endtask

	task automatic push_ctl(item_kind_t k, logic [1:0] idx, int val);
		stim_t s;
		s.kind = k; s.index = idx; s.data = val[12:0];
		s.r = '0; s.g = '0; s.b = '0; s.fs = 1'b0;
		pending.push_back(s);
	endtask

	// one setting of all registers, then a run of pixels from frame start
	task automatic push_phase(int w, int h, int rad, int lev, int npix, bit with_drain);
		logic [23:0] pal [4];
		int mode, k;
		logic [23:0] c;
		push_ctl(K_CFG, REG_WIDTH, w);
		push_ctl(K_CFG, REG_HEIGHT, h);
		push_ctl(K_CFG, REG_RADIUS, rad);
		push_ctl(K_CFG, REG_LEVELS, lev);
		mode = $urandom_range(2);
		for (int i = 0; i < 4; i++) pal[i] = 24'($urandom);
		for (int i = 0; i < npix; i++) begin
			k = $urandom_range(3);
			if (mode == 0) c = 24'($urandom);
			else if (mode == 1) c = pal[k];
			else c = pal[k] ^ {5'd0, 3'($urandom), 5'd0, 3'($urandom), 5'd0, 3'($urandom)};
			if (with_drain && i == npix / 2)
				push_ctl(K_DRAIN, REG_WIDTH, 0);
			push_pix(c[23:16], c[15:8], c[7:0], (i == 0) || ($urandom_range(199) == 0));
		end
	endtask

	// drive stimulus and update the predictor on every transfer
	always @(posedge clk or negedge arst_n) begin
		bit v_in, v_cfg;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			v_in = in_valid;
			v_cfg = cfg_valid;
			if (in_valid && in_ready) begin
				paint_pixel(pending[0]);
				void'(pending.pop_front());
				v_in = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				apply_cfg(pending[0]);
				void'(pending.pop_front());
				v_cfg = 1'b0;
			end
			quiet = (filtered_q.size() == 0) ? quiet + 1 : 0;
			if (!v_in && !v_cfg && pending.size() > 0) begin
				case (pending[0].kind)
					K_PIX: if (!idle_now()) begin
						v_in = 1'b1;
						red_in <= pending[0].r;
						green_in <= pending[0].g;
						blue_in <= pending[0].b;
						frame_start <= pending[0].fs;
					end
					K_CFG: if (quiet >= SETTLE) begin
						v_cfg = 1'b1;
						cfg_index <= pending[0].index;
						cfg_data <= pending[0].data;
					end
					K_DRAIN: if (quiet >= SETTLE) void'(pending.pop_front());
					default: ;
				endcase
			end
			in_valid <= v_in;
			cfg_valid <= v_cfg;
		end
	end

	// check each result transfer against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		pixel_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (filtered_q.size() == 0) begin
					$display("%0t: unexpected result %h %h %h fe=%b", $time,
						red_out, green_out, blue_out, frame_end);
					errors++;
				end else begin
					e = filtered_q.pop_front();
					if (red_out !== e.r) begin
						$display("%0t: red exp %h got %h", $time, e.r, red_out);
						errors++;
					end
					if (green_out !== e.g) begin
						$display("%0t: green exp %h got %h", $time, e.g, green_out);
						errors++;
					end
					if (blue_out !== e.b) begin
						$display("%0t: blue exp %h got %h", $time, e.b, blue_out);
						errors++;
					end
					if (frame_end !== e.fe) begin
						$display("%0t: frame_end exp %b got %b", $time, e.fe, frame_end);
						errors++;
					end
				end
			end
			out_ready <= !idle_now();
		end
	end

	// cycle count and timeout
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int rad, w, h, lev, n;
		// border pixels under the reset setting, extremes of each channel
		push_pix(8'h00, 8'h00, 8'h00, 1'b1);
		push_pix(8'hff, 8'hff, 8'hff, 1'b0);
		push_pix(8'hff, 8'h00, 8'h00, 1'b0);
		push_pix(8'h00, 8'hff, 8'h00, 1'b0);
		push_pix(8'h00, 8'h00, 8'hff, 1'b0);
		push_pix(8'h55, 8'haa, 8'h55, 1'b0);
		// register extremes and out of range values
		push_phase(1, 1, 1, 1, 4, 1'b0);
		push_phase(0, 0, 0, 0, 4, 1'b0);
		push_phase(2047, 1, 15, 63, 40, 1'b0);
		push_phase(1, 8191, 8, 32, 40, 1'b0);
		push_phase(3, 3, 1, 1, 10, 1'b0);
		// random well-formed frames, first one with a full drain midway
		push_phase(17, 17, 8, 32, 300, 1'b1);
		while (total_pix < PIX_TOTAL) begin
			rad = $urandom_range(1, 8);
			w = $urandom_range(2 * rad + 1, 2 * rad + 10);
			h = $urandom_range(2 * rad + 1, 2 * rad + 5);
			lev = $urandom_range(1, 32);
			n = w * h + $urandom_range(0, 2 * w);
			// stop the last run at the pixel budget
			if (n > PIX_TOTAL - total_pix) n = PIX_TOTAL - total_pix;
			push_phase(w, h, rad, lev, n, 1'b0);
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending.size() == 0 && filtered_q.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
